// ----- hw/rtl/cmt_pkg.sv -----
// ----------------------------------------------------------------------------
// cmt_pkg
// shared types, constants and helpers of the identifier-keyed mailbox table
// ----------------------------------------------------------------------------
`default_nettype none

package cmt_pkg;

	// table geometry
	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// field widths fixed by the frame format
	localparam int ID_W    = 32;
	localparam int LEN_W   = 4;
	localparam int DATA_W  = 64;
	localparam int SLOT_W  = 6;
	localparam int BYTES   = 8;

	localparam logic [ID_W-1:0]  EMPTY_ID = 32'h0000_0000;
	localparam logic [LEN_W-1:0] FULL_LEN = 4'd8;

	// command codes
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_TAKEN   = 2'd1,
		ST_DROPPED = 2'd2,
		ST_READ    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_HOLD
	} fsm_t;

	// request held for the whole scan and seen by every cell
	typedef struct packed {
		logic              cmd;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
		logic [SLOT_W-1:0] ridx;
	} req_t;

	// token record handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              hit;
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   eid;
		logic [LEN_W-1:0]  elen;
		logic [DATA_W-1:0] edata;
	} rec_t;

	// lengths above eight count as eight
	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
		return (len > FULL_LEN) ? FULL_LEN : len;
	endfunction

	// low bits of an entry number as reported on the result
	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_W-1:0] ext;
		ext = {{SLOT_W{1'b0}}, idx};
		return ext[SLOT_W-1:0];
	endfunction

	// read index against an entry number, both widened to a common width
	function automatic logic idx_match(input logic [SLOT_W-1:0] ridx,
	                                   input logic [IDX_W-1:0]  idx);
		logic [IDX_W+SLOT_W-1:0] a;
		logic [IDX_W+SLOT_W-1:0] b;
		a = {{IDX_W{1'b0}}, ridx};
		b = {{SLOT_W{1'b0}}, idx};
		return a == b;
	endfunction

	// overwrite the low len bytes, keep the rest
	function automatic logic [DATA_W-1:0] byte_merge(input logic [DATA_W-1:0] old_d,
	                                                 input logic [DATA_W-1:0] new_d,
	                                                 input logic [LEN_W-1:0]  len);
		logic [DATA_W-1:0] m;
		m = old_d;
		for (int b = 0; b < BYTES; b++) begin
			if (LEN_W'(b) < len) begin
				m[b*8 +: 8] = new_d[b*8 +: 8];
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cmt_item_if.sv -----
// ----------------------------------------------------------------------------
// cmt_item_if
// request channel: store a received frame or read an entry
// ----------------------------------------------------------------------------
`default_nettype none

interface cmt_item_if;
	import cmt_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [ID_W-1:0]   frame_id;
	logic [LEN_W-1:0]  frame_length;
	logic [DATA_W-1:0] frame_data;
	logic [SLOT_W-1:0] read_index;

	modport source (
		output valid, command, frame_id, frame_length, frame_data, read_index,
		input  ready
	);

	modport sink (
		input  valid, command, frame_id, frame_length, frame_data, read_index,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/cmt_result_if.sv -----
// ----------------------------------------------------------------------------
// cmt_result_if
// result channel: outcome of one request and the entry it touched
// ----------------------------------------------------------------------------
`default_nettype none

interface cmt_result_if;
	import cmt_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot;
	logic [ID_W-1:0]   entry_id;
	logic [LEN_W-1:0]  entry_length;
	logic [DATA_W-1:0] entry_data;

	modport source (
		output valid, status, slot, entry_id, entry_length, entry_data,
		input  ready
	);

	modport sink (
		input  valid, status, slot, entry_id, entry_length, entry_data,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/cmt_cell.sv -----
// ----------------------------------------------------------------------------
// cmt_cell
// one table entry with its compare logic and one stage of the token chain
// ----------------------------------------------------------------------------
`default_nettype none

module cmt_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [cmt_pkg::IDX_W-1:0] index,
	input  wire cmt_pkg::req_t         req,
	input  wire cmt_pkg::rec_t         rin,
	output      cmt_pkg::rec_t         rout
);
	import cmt_pkg::*;

	logic [ID_W-1:0]   id_q;
	logic [LEN_W-1:0]  len_q;
	logic [DATA_W-1:0] bytes_q;
	rec_t              rec_q;

	logic              is_empty;
	logic              hit_here;
	logic              rd_here;
	logic [DATA_W-1:0] merged;
	rec_t              rec_d;

	// first free or matching entry claims the store, a read picks its index
	assign is_empty = (id_q == EMPTY_ID);
	assign hit_here = rin.valid && (req.cmd == CMD_STORE) && !rin.hit &&
	                  (is_empty || (id_q == req.id));
	assign rd_here  = rin.valid && (req.cmd == CMD_READ) && idx_match(req.ridx, index);
	assign merged   = byte_merge(bytes_q, req.data, req.len);

	// record handed to the next cell
	always_comb begin
		rec_d = rin;
		if (hit_here) begin
			rec_d.hit    = 1'b1;
			rec_d.status = is_empty ? ST_TAKEN : ST_UPDATED;
			rec_d.slot   = to_slot(index);
			rec_d.eid    = req.id;
			rec_d.elen   = req.len;
			rec_d.edata  = merged;
		end else if (rd_here) begin
			rec_d.eid    = id_q;
			rec_d.elen   = len_q;
			rec_d.edata  = bytes_q;
		end
	end

	// entry contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q    <= EMPTY_ID;
			len_q   <= FULL_LEN;
			bytes_q <= '0;
		end else if (hit_here) begin
			id_q    <= req.id;
			len_q   <= req.len;
			bytes_q <= merged;
		end
	end

	// chain stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= rec_d;
		end
	end

	assign rout = rec_q;

endmodule

`default_nettype wire

// ----- hw/rtl/can_id_mailbox_table.sv -----
// ----------------------------------------------------------------------------
// can_id_mailbox_table
// latest received CAN frame per identifier, held in a chain of entry cells
// ----------------------------------------------------------------------------
// Each entry lives in its own cell; a request token walks the row of cells
// one cell per cycle, entry 0 first. On a store the first cell that is empty
// (identifier zero) or already holds the identifier claims the frame, writes
// identifier, saturated length and the low length bytes, and marks the token
// so later cells leave it alone; if no cell claims it the frame is dropped.
// On a read the cell at read_index copies its entry into the token. One
// request is in flight at a time. The result passes through the launch
// register, then the chain register of each cell, and is then loaded into
// the output register. The next request is taken from the cycle the result
// shows. A finished result waits in the output register while the next
// request is taken; if the output register is still occupied when a scan
// ends, the result waits in a holding register behind it and no request is
// taken until it moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module can_id_mailbox_table (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cmt_item_if.sink    item,
	cmt_result_if.source result
);
	import cmt_pkg::*;

	fsm_t state_q;
	fsm_t state_d;

	req_t req_q;
	rec_t launch_q;
	rec_t park_q;
	rec_t out_q;
	logic out_valid_q;

	rec_t link [ENTRIES+1];
	logic [ENTRIES:0] tok_vec;

	logic item_xfer;
	logic out_free;
	logic load_out;
	logic load_park;
	logic from_park;
	logic chain_done;

	assign item_xfer  = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;
	assign chain_done = link[ENTRIES].valid;

	// request held for the scan, token launched into cell 0
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			req_q.cmd  <= item.command;
			req_q.id   <= item.frame_id;
			req_q.len  <= sat_len(item.frame_length);
			req_q.data <= item.frame_data;
			req_q.ridx <= item.read_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
		end else begin
			launch_q.valid  <= item_xfer;
			launch_q.hit    <= 1'b0;
			launch_q.status <= (item.command == CMD_READ) ? ST_READ : ST_DROPPED;
			launch_q.slot   <= (item.command == CMD_READ) ? item.read_index : '0;
			launch_q.eid    <= '0;
			launch_q.elen   <= '0;
			launch_q.edata  <= '0;
		end
	end

	// row of entry cells
	assign link[0]    = launch_q;
	assign tok_vec[0] = launch_q.valid;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		cmt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.index  (IDX_W'(i)),
			.req    (req_q),
			.rin    (link[i]),
			.rout   (link[i+1])
		);
		assign tok_vec[i+1] = link[i+1].valid;
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (item_xfer) begin
					state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (chain_done) begin
					state_d = out_free ? FSM_IDLE : FSM_HOLD;
				end
			end
			FSM_HOLD: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item.ready = 1'b0;
		load_out   = 1'b0;
		load_park  = 1'b0;
		from_park  = 1'b0;
		case (state_q)
			FSM_IDLE: item.ready = 1'b1;
			FSM_SCAN: begin
				load_out  = chain_done && out_free;
				load_park = chain_done && !out_free;
			end
			FSM_HOLD: begin
				load_out  = out_free;
				from_park = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// holding register for a result that finds the output occupied
	always_ff @(posedge clk) begin
		if (load_park) begin
			park_q <= link[ENTRIES];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= from_park ? park_q : link[ENTRIES];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = out_q.status;
	assign result.slot         = out_q.slot;
	assign result.entry_id     = out_q.eid;
	assign result.entry_length = out_q.elen;
	assign result.entry_data   = out_q.edata;

	// at most one token anywhere in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one token in the cell chain");

	// a transfer launches a token in the next cycle
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |=> launch_q.valid)
		else $error("accepted request not launched");

	// no token travels while the sequencer is idle or holding
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_IDLE || state_q == FSM_HOLD) |-> (tok_vec[ENTRIES:1] == '0))
		else $error("token in chain outside a scan");

	// a finishing token always has somewhere to go
	a_done_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain_done |-> (state_q == FSM_SCAN))
		else $error("chain finished outside a scan");

	// while holding, the output register is occupied by the earlier result
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_HOLD) |-> out_valid_q)
		else $error("holding with an empty output register");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the identifier-keyed CAN mailbox table
// ----------------------------------------------------------------------------
// Requests go in on the item channel and results come back on the result
// channel, one result per request. A short table of hand-written requests
// runs first. It covers the reset contents, the length extremes, a store of
// identifier zero and updates of entries that already exist. A random mix of
// stores and reads follows. Most stores draw from a pool of identifiers that
// is a little larger than the table, so the table fills up and later new
// identifiers are dropped. Results are checked against the typed expectation,
// or else a predictor that keeps its own copy of the table. Both sides idle
// in short random bursts, and once the receiver holds off for a long stretch.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cmt_pkg::*;

	localparam int TOTAL_REQS   = 850;
	localparam int QUIET_TAIL   = 120;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 500;
	localparam int POOL_SIZE    = ENTRIES + 8;
	localparam int DRAIN_CYCLES = ENTRIES + 16;
	localparam int LIMIT_CYCLES = 300000;

	// outcome of one request as seen on the result channel
	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
	} mbox_res_t;

	typedef struct {
		req_t      req;
		bit        typed;
		mbox_res_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	cmt_item_if   item ();
	cmt_result_if result ();

	can_id_mailbox_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	// predictor copy of the table
	logic [ID_W-1:0]   tbl_id   [ENTRIES];
	logic [LEN_W-1:0]  tbl_len  [ENTRIES];
	logic [DATA_W-1:0] tbl_data [ENTRIES];

	mbox_res_t  pending_q [$];
	logic [ID_W-1:0] id_pool [POOL_SIZE];

	int  reqs_sent;
	int  errors;
	int  cycles;
	int  n_updated;
	int  n_taken;
	int  n_dropped;
	int  n_read;
	bit  quiet;
	bit  hold_due;
	bit  hold_done;

	// directed requests; expectations typed in where they are plain to see
	stim_row_t dir_rows [16] = '{
		'{'{CMD_READ,  32'h0000_0000, 4'd0,  64'h0, 6'd0},  1'b1,
			'{ST_READ, 6'd0, 32'h0, 4'd8, 64'h0}},
		'{'{CMD_READ,  32'h0000_0000, 4'd0,  64'h0, 6'd63}, 1'b1,
			'{ST_READ, 6'd63, 32'h0, 4'd8, 64'h0}},
		'{'{CMD_STORE, 32'h0000_0123, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 6'd0}, 1'b1,
			'{ST_TAKEN, 6'd0, 32'h0000_0123, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF}},
		'{'{CMD_STORE, 32'h0000_0123, 4'd0,  64'h0, 6'd0},  1'b1,
			'{ST_UPDATED, 6'd0, 32'h0000_0123, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF}},
		'{'{CMD_STORE, 32'h0000_0123, 4'd3,  64'h0, 6'd0},  1'b1,
			'{ST_UPDATED, 6'd0, 32'h0000_0123, 4'd3, 64'hFFFF_FFFF_FF00_0000}},
		'{'{CMD_STORE, 32'hFFFF_FFFF, 4'd15, 64'h0123_4567_89AB_CDEF, 6'd0}, 1'b1,
			'{ST_TAKEN, 6'd1, 32'hFFFF_FFFF, 4'd8, 64'h0123_4567_89AB_CDEF}},
		'{'{CMD_STORE, 32'h0000_0000, 4'd2,  64'h1111_2222_3333_AAAA, 6'd0}, 1'b1,
			'{ST_TAKEN, 6'd2, 32'h0, 4'd2, 64'h0000_0000_0000_AAAA}},
		'{'{CMD_STORE, 32'h8000_0000, 4'd9,  64'hFEDC_BA98_7654_3210, 6'd0}, 1'b0, '0},
		'{'{CMD_READ,  32'h0000_0000, 4'd0,  64'h0, 6'd2},  1'b0, '0},
		'{'{CMD_STORE, 32'hFFFF_FFFF, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 6'd0}, 1'b0, '0},
		'{'{CMD_STORE, 32'h1FFF_FFFF, 4'd1,  64'hA5A5_A5A5_A5A5_A5A5, 6'd0}, 1'b0, '0},
		'{'{CMD_STORE, 32'h0000_0123, 4'd8,  64'h0, 6'd0},  1'b0, '0},
		'{'{CMD_STORE, 32'h1FFF_FFFF, 4'd7,  64'h5A5A_5A5A_5A5A_5A5A, 6'd0}, 1'b0, '0},
		'{'{CMD_STORE, 32'h0000_0001, 4'd4,  64'h0F0F_0F0F_0F0F_0F0F, 6'd0}, 1'b0, '0},
		'{'{CMD_READ,  32'hFFFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 6'd1}, 1'b0, '0},
		'{'{CMD_READ,  32'h0000_0000, 4'd0,  64'h0, 6'd0},  1'b0, '0}
	};

	// clock
	initial clk = 1'b0;
	always #5ns clk = ~clk;

	// apply one request to the predictor table and return its outcome
	function automatic mbox_res_t mailbox_apply(input req_t r);
		mbox_res_t         o;
		int                hit;
		logic [LEN_W-1:0]  n;
		logic [DATA_W-1:0] mask;
		o = '0;
		if (r.cmd == CMD_READ) begin
			o.status = ST_READ;
			o.slot   = r.ridx;
			if (int'(r.ridx) < ENTRIES) begin
				o.id   = tbl_id[r.ridx];
				o.len  = tbl_len[r.ridx];
				o.data = tbl_data[r.ridx];
			end
			return o;
		end
		n = (r.len > FULL_LEN) ? FULL_LEN : r.len;
		hit = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit < 0 && (tbl_id[i] == EMPTY_ID || tbl_id[i] == r.id)) begin
				hit = i;
			end
		end
		if (hit < 0) begin
			o.status = ST_DROPPED;
			return o;
		end
		o.status = (tbl_id[hit] == EMPTY_ID) ? ST_TAKEN : ST_UPDATED;
		mask = (n == FULL_LEN) ? '1 : ((64'd1 << (int'(n) * 8)) - 64'd1);
		tbl_id[hit]   = r.id;
		tbl_len[hit]  = n;
		tbl_data[hit] = (tbl_data[hit] & ~mask) | (r.data & mask);
		o.slot = SLOT_W'(hit);
		o.id   = tbl_id[hit];
		o.len  = tbl_len[hit];
		o.data = tbl_data[hit];
		return o;
	endfunction

	// present one request, wait for its transfer, record what should come back
	task automatic offer(input req_t r, input bit typed, input mbox_res_t typed_res);
		mbox_res_t predicted;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item.valid        <= 1'b1;
		item.command      <= r.cmd;
		item.frame_id     <= r.id;
		item.frame_length <= r.len;
		item.frame_data   <= r.data;
		item.read_index   <= r.ridx;
		do @(posedge clk); while (!item.ready);
		predicted = mailbox_apply(r);
		pending_q.push_back(typed ? typed_res : predicted);
		reqs_sent++;
		if (reqs_sent == HOLD_AT) hold_due = 1'b1;
		if (reqs_sent >= TOTAL_REQS - QUIET_TAIL) quiet = 1'b1;
	endtask

	function automatic bit field_ok(input string name, input logic [DATA_W-1:0] want,
	                                input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// reset and stimulus
	initial begin
		req_t r;
		int   pick;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_id[i]   = EMPTY_ID;
			tbl_len[i]  = FULL_LEN;
			tbl_data[i] = '0;
		end
		for (int i = 0; i < POOL_SIZE; i++) begin
			id_pool[i] = $urandom();
			if (id_pool[i] == EMPTY_ID) id_pool[i] = 32'h0000_0001 + i;
		end
		reqs_sent = 0;
		errors    = 0;
		quiet     = 1'b0;
		hold_due  = 1'b0;
		arst_n            <= 1'b0;
		item.valid        <= 1'b0;
		item.command      <= CMD_STORE;
		item.frame_id     <= '0;
		item.frame_length <= '0;
		item.frame_data   <= '0;
		item.read_index   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[k]) begin
			offer(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
		end

		// random mix: pool stores fill the table, then new identifiers drop
		while (reqs_sent < TOTAL_REQS) begin
			pick   = $urandom_range(0, 99);
			r.len  = LEN_W'($urandom_range(0, 15));
			r.data = {$urandom(), $urandom()};
			r.ridx = SLOT_W'($urandom_range(0, ENTRIES - 1));
			r.cmd  = (pick < 30) ? CMD_READ : CMD_STORE;
			if (pick < 85) begin
				r.id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
			end else if (pick < 95) begin
				r.id = $urandom();
			end else begin
				r.id = ($urandom_range(0, 1) == 0) ? EMPTY_ID : 32'hFFFF_FFFF;
			end
			offer(r, 1'b0, '0);
		end
		item.valid <= 1'b0;

		// let the last results drain
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d requests after reset: %0d new entries, %0d updates,",
		         reqs_sent, n_taken, n_updated);
		$display("%0d frames dropped on a full table and %0d reads, %0d errors",
		         n_dropped, n_read, errors);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// receiver: short stalls, one long hold-off, none near the end
	initial begin
		hold_done = 1'b0;
		result.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		result.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_due && !hold_done) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				result.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				result.ready <= 1'b1;
			end
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		mbox_res_t want;
		bit        ok;
		if (arst_n && result.valid && result.ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result with nothing expected, status %h slot %0d id %h",
				         $time, result.status, result.slot, result.entry_id);
				errors++;
			end else begin
				want = pending_q.pop_front();
				ok = 1'b1;
				ok &= field_ok("status", 64'(want.status), 64'(result.status));
				ok &= field_ok("slot", 64'(want.slot), 64'(result.slot));
				ok &= field_ok("entry_id", 64'(want.id), 64'(result.entry_id));
				ok &= field_ok("entry_length", 64'(want.len), 64'(result.entry_length));
				ok &= field_ok("entry_data", want.data, result.entry_data);
				if (!ok) errors++;
				case (want.status)
					ST_UPDATED: n_updated++;
					ST_TAKEN:   n_taken++;
					ST_DROPPED: n_dropped++;
					default:    n_read++;
				endcase
			end
		end
	end

	// watchdog
	initial begin
		cycles    = 0;
		n_updated = 0;
		n_taken   = 0;
		n_dropped = 0;
		n_read    = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d requests sent and %0d results outstanding",
			         $time, reqs_sent, pending_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
